[hw/rtl/gld_pkg.sv]
package gld_pkg;

   localparam int unsigned MAX_CODE_BITS_DEF = 12;
   localparam int unsigned STACK_DEPTH_DEF   = 4096;

   localparam logic [2:0] ST_PIXEL    = 3'd0;
   localparam logic [2:0] ST_ACCEPTED = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_NEED     = 3'd3;
   localparam logic [2:0] ST_END      = 3'd4;
   localparam logic [2:0] ST_OUT      = 3'd5;
   localparam logic [2:0] ST_BAD      = 3'd6;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_PULL = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_WALK_RD,
      S_WALK,
      S_POP_RD,
      S_POP,
      S_RESP
   } state_type;

endpackage

[hw/rtl/gld_if.sv]
interface gld_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;
   logic       first_byte;
   modport source (output valid, action, data_byte, first_byte, input ready);
   modport sink   (input valid, action, data_byte, first_byte, output ready);
endinterface

interface gld_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] pixel;
   modport source (output valid, status, pixel, input ready);
   modport sink   (input valid, status, pixel, output ready);
endinterface

[hw/rtl/gld_ram.sv]
module gld_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[hw/rtl/gif_lzw_decoder.sv]
// GIF LZW decoder.
// req channel: action 0 pushes one image-data byte (first_byte marks the
// minimum code size and restarts the image); action 1 pulls one pixel.
// rsp channel: one transaction per request with status and pixel.
// A push goes from S_IDLE to S_RESP. A pull that pops a queued pixel runs
// S_DECODE, S_POP_RD and S_POP before S_RESP. A pull that answers straight
// from the bit buffer (first code after a start or clear, need bytes, out of
// data, end code, code out of range) goes from S_DECODE to S_RESP. A pull that
// decodes a code runs an S_WALK_RD, S_WALK pair for each prefix-chain node,
// root included, since each node needs a registered read of the prefix and
// suffix RAMs, then pops a pixel. A clear code returns to S_DECODE first.
// One request is in work at a time; req_ready is low until the response
// has been taken, so a stalled receiver holds the whole block.
// Reset is synchronous and active high; it restores code size 8 and empties
// the bit buffer and pixel stack. The tables are not cleared; a decoded
// stream always writes an entry before it reads it.
module gif_lzw_decoder #(
   parameter int unsigned MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF,
   parameter int unsigned STACK_DEPTH   = gld_pkg::STACK_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   gld_req_if.sink   req,
   gld_rsp_if.source rsp
);
   localparam int unsigned CB  = MAX_CODE_BITS;
   localparam int unsigned SB  = $clog2(STACK_DEPTH);
   localparam int unsigned CSP = 1 << CB;

   gld_pkg::state_type state_ff, state_in;

   logic [CB-1:0] prev_ff, prev_in;
   logic [CB-1:0] walk_ff, walk_in;
   logic [CB-1:0] code_ff, code_in;
   logic [CB:0]   nfc_ff, nfc_in;
   logic [CB:0]   limit_ff, limit_in;
   logic [SB:0]   sp_ff, sp_in;
   logic [3:0]    root_ff, root_in;
   logic [3:0]    cw_ff, cw_in;
   logic [7:0]    first_ff, first_in;
   logic          fresh_ff, fresh_in;
   logic [31:0]   buf_ff, buf_in;
   logic [5:0]    fill_ff, fill_in;
   logic [7:0]    blk_ff, blk_in;
   logic          ended_ff, ended_in;
   logic [2:0]    status_ff, status_in;
   logic [7:0]    pixel_ff, pixel_in;
   logic          act_ff, act_in;
   logic          fb_ff, fb_in;

   logic          tab_we;
   logic [CB-1:0] tab_rd;
   logic [CB-1:0] pre_q;
   logic [7:0]    suf_q;
   logic          stk_we;
   logic [SB-1:0] stk_wa, stk_ra;
   logic [7:0]    stk_wd, stk_q;

   gld_ram #(.WIDTH(CB), .DEPTH(CSP)) u_prefix (
      .clock, .wr_en(tab_we), .wr_addr(nfc_ff[CB-1:0]), .wr_data(prev_ff),
      .rd_addr(tab_rd), .rd_data(pre_q));
   gld_ram #(.WIDTH(8), .DEPTH(CSP)) u_suffix (
      .clock, .wr_en(tab_we), .wr_addr(nfc_ff[CB-1:0]), .wr_data(first_in),
      .rd_addr(tab_rd), .rd_data(suf_q));
   gld_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
      .clock, .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_addr(stk_ra), .rd_data(stk_q));

   logic [CB-1:0] clr_code, mask, cur_code;
   logic [12:0]   clear13;
   always_comb begin
      clear13    = 13'd1 << root_ff;
      clr_code   = clear13[CB-1:0];
      mask       = CB'((32'd1 << cw_ff) - 32'd1);
      cur_code   = buf_ff[CB-1:0] & mask;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gld_pkg::S_IDLE: begin
            if (req.valid) begin
               state_in = (req.action == gld_pkg::ACT_PULL) ? gld_pkg::S_DECODE
                                                            : gld_pkg::S_RESP;
            end
         end
         gld_pkg::S_DECODE: begin
            if (sp_ff != '0) begin
               state_in = gld_pkg::S_POP_RD;
            end else if ({2'b0, fill_ff} < {4'b0, cw_ff}) begin
               state_in = gld_pkg::S_RESP;
            end else if (cur_code == clr_code) begin
               state_in = gld_pkg::S_DECODE;
            end else if (cur_code == clr_code + 1'b1 || fresh_ff
                         || {1'b0, cur_code} > nfc_ff) begin
               state_in = gld_pkg::S_RESP;
            end else begin
               state_in = gld_pkg::S_WALK_RD;
            end
         end
         gld_pkg::S_WALK_RD: state_in = gld_pkg::S_WALK;
         gld_pkg::S_WALK: begin
            if (sp_ff >= (SB+1)'(STACK_DEPTH)) begin
               state_in = gld_pkg::S_RESP;
            end else if (walk_ff >= clr_code) begin
               state_in = (pre_q == walk_ff) ? gld_pkg::S_RESP : gld_pkg::S_WALK_RD;
            end else begin
               state_in = gld_pkg::S_DECODE;
            end
         end
         gld_pkg::S_POP_RD: state_in = gld_pkg::S_POP;
         gld_pkg::S_POP:    state_in = gld_pkg::S_RESP;
         gld_pkg::S_RESP:   if (rsp.ready) state_in = gld_pkg::S_IDLE;
         default:           state_in = gld_pkg::S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      prev_in = prev_ff;  walk_in = walk_ff;  code_in = code_ff;
      nfc_in = nfc_ff;    limit_in = limit_ff; sp_in = sp_ff;
      root_in = root_ff;  cw_in = cw_ff;       first_in = first_ff;
      fresh_in = fresh_ff; buf_in = buf_ff;    fill_in = fill_ff;
      blk_in = blk_ff;    ended_in = ended_ff; status_in = status_ff;
      pixel_in = pixel_ff; act_in = act_ff;
      fb_in = fb_ff;
      tab_we = 1'b0; tab_rd = walk_ff;
      stk_we = 1'b0; stk_wa = sp_ff[SB-1:0]; stk_wd = suf_q;
      stk_ra = sp_ff[SB-1:0] - 1'b1;
      unique case (state_ff)
         gld_pkg::S_IDLE: begin
            act_in = req.action; fb_in = req.first_byte;
            pixel_in = '0; status_in = gld_pkg::ST_ACCEPTED;
            if (req.valid && req.action == gld_pkg::ACT_PUSH) begin
               if (req.first_byte) begin
                  root_in = (req.data_byte < 8'd2) ? 4'd2
                          : (req.data_byte > 8'd8) ? 4'd8 : req.data_byte[3:0];
                  cw_in    = root_in + 4'd1;
                  nfc_in   = (CB+1)'((13'd1 << root_in) + 13'd2);
                  limit_in = (CB+1)'(13'd1 << (root_in + 4'd1));
                  fresh_in = 1'b1; sp_in = '0;
                  buf_in = '0; fill_in = '0; blk_in = '0; ended_in = 1'b0;
               end else if (!ended_ff) begin
                  if (blk_ff == '0) begin
                     if (req.data_byte == '0) ended_in = 1'b1;
                     else blk_in = req.data_byte;
                  end else if (fill_ff > 6'd24) begin
                     status_in = gld_pkg::ST_FULL;
                  end else begin
                     buf_in  = buf_ff | ({24'd0, req.data_byte} << fill_ff);
                     fill_in = fill_ff + 6'd8;
                     blk_in  = blk_ff - 8'd1;
                  end
               end
            end
         end
         gld_pkg::S_DECODE: begin
            if (sp_ff != '0) begin
               sp_in = sp_ff - 1'b1;
            end else if ({2'b0, fill_ff} < {4'b0, cw_ff}) begin
               status_in = ended_ff ? gld_pkg::ST_OUT : gld_pkg::ST_NEED;
            end else begin
               buf_in  = buf_ff >> cw_ff;
               fill_in = fill_ff - {2'b0, cw_ff};
               code_in = cur_code;
               if (cur_code == clr_code) begin
                  cw_in    = root_ff + 4'd1;
                  nfc_in   = (CB+1)'(clear13 + 13'd2);
                  limit_in = (CB+1)'(13'd1 << (root_ff + 4'd1));
                  fresh_in = 1'b1;
               end else if (cur_code == clr_code + 1'b1) begin
                  ended_in = 1'b1; buf_in = '0; fill_in = '0; blk_in = '0;
                  status_in = gld_pkg::ST_END;
               end else if (fresh_ff) begin
                  if (cur_code > clr_code) begin
                     status_in = gld_pkg::ST_BAD;
                  end else begin
                     first_in = cur_code[7:0]; prev_in = cur_code; fresh_in = 1'b0;
                     pixel_in = cur_code[7:0]; status_in = gld_pkg::ST_PIXEL;
                  end
               end else if ({1'b0, cur_code} > nfc_ff) begin
                  status_in = gld_pkg::ST_BAD;
               end else if ({1'b0, cur_code} == nfc_ff) begin
                  stk_we = 1'b1; stk_wa = '0; stk_wd = first_ff;
                  sp_in = (SB+1)'(1); walk_in = prev_ff;
               end else begin
                  walk_in = cur_code;
               end
            end
         end
         gld_pkg::S_WALK_RD: ;
         gld_pkg::S_WALK: begin
            if (sp_ff >= (SB+1)'(STACK_DEPTH)) begin
               sp_in = '0; status_in = gld_pkg::ST_BAD;
            end else if (walk_ff >= clr_code) begin
               if (pre_q == walk_ff) begin
                  sp_in = '0; status_in = gld_pkg::ST_BAD;
               end else begin
                  stk_we = 1'b1; stk_wd = suf_q;
                  sp_in = sp_ff + 1'b1; walk_in = pre_q;
               end
            end else begin
               // chain reached a root: push it and grow the table
               stk_we = 1'b1; stk_wd = walk_ff[7:0];
               sp_in = sp_ff + 1'b1; first_in = walk_ff[7:0];
               if (nfc_ff < (CB+1)'(CSP)) begin
                  tab_we = 1'b1;
                  nfc_in = nfc_ff + 1'b1;
                  if (nfc_in >= limit_ff && limit_ff < (CB+1)'(CSP)) begin
                     limit_in = limit_ff << 1; cw_in = cw_ff + 4'd1;
                  end
               end
               prev_in = code_ff;
            end
         end
         gld_pkg::S_POP_RD: ;
         gld_pkg::S_POP: begin
            pixel_in = stk_q; status_in = gld_pkg::ST_PIXEL;
         end
         gld_pkg::S_RESP: ;
         default: ;
      endcase
      if (state_ff == gld_pkg::S_POP_RD || state_ff == gld_pkg::S_POP) begin
         stk_ra = sp_ff[SB-1:0];
      end
   end

   always_comb begin
      req.ready  = (state_ff == gld_pkg::S_IDLE);
      rsp.valid  = (state_ff == gld_pkg::S_RESP);
      rsp.status = status_ff;
      rsp.pixel  = pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gld_pkg::S_IDLE;
         root_ff <= 4'd8; cw_ff <= 4'd9;
         nfc_ff <= (CB+1)'(258); limit_ff <= (CB+1)'(512);
         sp_ff <= '0; first_ff <= '0; prev_ff <= '0; fresh_ff <= 1'b1;
         buf_ff <= '0; fill_ff <= '0; blk_ff <= '0; ended_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         root_ff <= root_in; cw_ff <= cw_in; nfc_ff <= nfc_in; limit_ff <= limit_in;
         sp_ff <= sp_in; first_ff <= first_in; prev_ff <= prev_in;
         fresh_ff <= fresh_in; buf_ff <= buf_in; fill_ff <= fill_in;
         blk_ff <= blk_in; ended_ff <= ended_in;
      end
      walk_ff <= walk_in; code_ff <= code_in; status_ff <= status_in;
      pixel_ff <= pixel_in; act_ff <= act_in; fb_ff <= fb_in;
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 6'd32) else $error("bit fill beyond buffer");
   a_pixel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != gld_pkg::ST_PIXEL |-> rsp.pixel == '0)
      else $error("pixel set on non-pixel status");
   a_push_status: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && act_ff == gld_pkg::ACT_PUSH |->
         (rsp.status == gld_pkg::ST_ACCEPTED || rsp.status == gld_pkg::ST_FULL))
      else $error("bad push status");
   a_first_ok: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && act_ff == gld_pkg::ACT_PUSH && fb_ff |->
         rsp.status == gld_pkg::ST_ACCEPTED)
      else $error("start of image refused");
   a_cw_range: assert property (@(posedge clock) disable iff (reset)
      cw_ff >= 4'd3 && cw_ff <= 4'(CB)) else $error("code width out of range");
endmodule
